@@ design/tzt_pkg.sv @@
// ----------------------------------------------------------------------------
// tzt_pkg
// Shared constants and types for the tag zone tracker.
// ----------------------------------------------------------------------------
package tzt_pkg;

  localparam int TagSlotsDef = 16;
  localparam int ScannersDef = 8;

  localparam logic [31:0] WindowRst = 32'd5000;
  localparam logic [7:0]  HystRst   = 8'd5;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_FIND   = 3'd1,
    CMD_REPORT = 3'd2,
    CMD_SETZ   = 3'd3,
    CMD_EVAL   = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_HYST   = 1'b1;

  // One accepted transaction as it travels from front to back.
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] tag_key;
    logic [7:0]  tag_kind;
    logic [3:0]  scanner_num;
    logic [7:0]  signal_dbm;
    logic [31:0] now_ms;
    logic [3:0]  zone_value;
  } cmd_item_t;

endpackage

@@ design/tzt_queue.sv @@
// ----------------------------------------------------------------------------
// tzt_queue
// Small two-entry queue between the front and the back part.
// ----------------------------------------------------------------------------
module tzt_queue import tzt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  cmd_item_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output cmd_item_t rd_data,
  output logic      empty
);

  cmd_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

@@ design/tzt_engine.sv @@
// ----------------------------------------------------------------------------
// tzt_engine
// Back part: walks the slot table and scanner samples for one command.
// ----------------------------------------------------------------------------
module tzt_engine import tzt_pkg::*; #(
  parameter int TAG_SLOTS = TagSlotsDef,
  parameter int SCANNERS  = ScannersDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_item_t   q_data,
  output logic        q_pop,
  input  logic [31:0] window_ms,
  input  logic [7:0]  hyst_db,
  output logic        res_valid,
  output logic [1:0]  res_status,
  output logic [3:0]  res_slot,
  output logic [3:0]  res_zone,
  input  logic        res_take
);

  localparam int SW = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
  localparam int CW = (SCANNERS > 1) ? $clog2(SCANNERS) : 1;
  localparam int NS = TAG_SLOTS * SCANNERS;
  localparam int KW = (NS > 1) ? $clog2(NS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DO, S_EVAL, S_DONE, S_CLR
  } state_t;

  state_t state_r;
  cmd_item_t cur_r;
  logic [SW:0] idx_r;
  logic [CW:0] sc_r;
  logic hit_r, free_r;
  logic [SW-1:0] hslot_r, fslot_r, slot_r;
  logic [TAG_SLOTS-1:0] act_r;
  logic [15:0] tag_r [TAG_SLOTS];
  logic [3:0] zone_r [TAG_SLOTS];
  logic [NS-1:0] sval_r;
  logic signed [9:0] best_r, curr_r;
  logic [3:0] bestz_r;
  logic curf_r;
  logic [1:0] st_r;
  logic [3:0] oz_r;
  logic ov_r;
  logic [1:0] res_st_r;
  logic [3:0] res_slot_r, res_zone_r;

  // Sample storage: rssi and time in one memory
  logic        rwe;
  logic [KW-1:0] raddr, waddr;
  logic [39:0] rwd, rrd;
  tzt_ram #(.WIDTH(40), .DEPTH(NS)) u_ram (
    .clk(clk), .we(rwe), .waddr(waddr), .wdata(rwd), .raddr(raddr), .rdata(rrd)
  );

  logic [KW-1:0] base;
  assign base  = KW'(slot_r) * KW'(SCANNERS);
  assign raddr = base + KW'(sc_r[CW-1:0]);

  logic [3:0] scan_m1;
  assign scan_m1 = cur_r.scanner_num - 4'd1;
  logic scan_ok;
  assign scan_ok = (cur_r.scanner_num != 4'd0) &&
                   ({28'd0, cur_r.scanner_num} <= 32'(SCANNERS));
  assign waddr = base + KW'(scan_m1);
  assign rwd   = {cur_r.signal_dbm, cur_r.now_ms};
  assign rwe   = (state_r == S_DO) && (cur_r.command == CMD_REPORT) && scan_ok &&
                 (hit_r || free_r);

  assign q_pop      = (state_r == S_IDLE) && !q_empty;
  assign res_valid  = ov_r;
  assign res_status = res_st_r;
  assign res_slot   = res_slot_r;
  assign res_zone   = res_zone_r;

  // Sample read arrives the cycle after its address; prev index in flight
  logic [CW:0] scp_r;
  logic rdv_r;
  logic [KW-1:0] kp;
  assign kp = base + KW'(scp_r[CW-1:0]);

  logic signed [9:0] rs;
  logic [31:0] age;
  assign rs  = 10'(signed'(rrd[39:32]));
  assign age = cur_r.now_ms - rrd[31:0];

  logic [3:0] znum;
  assign znum = 4'(scp_r) + 4'd1;

  logic signed [9:0] diff;
  assign diff = best_r - curr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      act_r   <= '0;
      sval_r  <= '0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (res_take) ov_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          act_r   <= '0;
          sval_r  <= '0;
          for (int i = 0; i < TAG_SLOTS; i++) zone_r[i] <= 4'd0;
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur_r   <= q_data;
            idx_r   <= '0;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Walk slots: first match, first free
          if (idx_r == (SW+1)'(TAG_SLOTS)) begin
            state_r <= S_DO;
            if (hit_r) slot_r <= hslot_r;
            else slot_r <= fslot_r;
          end else begin
            if (!hit_r && act_r[idx_r[SW-1:0]] &&
                tag_r[idx_r[SW-1:0]] == cur_r.tag_key) begin
              hit_r <= 1'b1; hslot_r <= idx_r[SW-1:0];
            end
            if (!free_r && !act_r[idx_r[SW-1:0]]) begin
              free_r <= 1'b1; fslot_r <= idx_r[SW-1:0];
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DO: begin
          st_r    <= ST_OK;
          oz_r    <= 4'(slot_r);
          bestz_r <= 4'd0;
          state_r <= S_DONE;
          case (cur_r.command)
            CMD_CLEAR: begin
              oz_r <= 4'd0;
              act_r <= '0; sval_r <= '0;
              for (int i = 0; i < TAG_SLOTS; i++) zone_r[i] <= 4'd0;
            end
            CMD_FIND: if (!hit_r) begin st_r <= ST_NOTFOUND; oz_r <= 4'd0; end
            CMD_SETZ: begin
              if (!hit_r) begin st_r <= ST_NOTFOUND; oz_r <= 4'd0; end
              else zone_r[slot_r] <= cur_r.zone_value;
            end
            CMD_REPORT: begin
              if (!hit_r && !free_r) begin
                st_r <= ST_FULL; oz_r <= 4'd0;
              end else begin
                if (!hit_r) begin
                  act_r[slot_r] <= 1'b1;
                  tag_r[slot_r] <= cur_r.tag_key;
                  zone_r[slot_r] <= 4'd0;
                  for (int i = 0; i < SCANNERS; i++)
                    sval_r[KW'(base) + KW'(i)] <= 1'b0;
                end
                if (scan_ok) sval_r[waddr] <= 1'b1;
              end
            end
            CMD_EVAL: begin
              if (!hit_r) begin st_r <= ST_NOTFOUND; oz_r <= 4'd0; end
              else begin
                sc_r <= '0; rdv_r <= 1'b0;
                best_r <= -10'sd300; curr_r <= 10'sd0; curf_r <= 1'b0;
                state_r <= S_EVAL;
              end
            end
            default: oz_r <= 4'd0;
          endcase
        end
        S_EVAL: begin
          // Issue next read, consume previous
          scp_r <= sc_r;
          rdv_r <= (sc_r != (CW+1)'(SCANNERS));
          if (sc_r != (CW+1)'(SCANNERS)) sc_r <= sc_r + 1'b1;
          if (rdv_r && sval_r[kp]) begin
            if (age > window_ms) sval_r[kp] <= 1'b0;
            else begin
              if (rs > best_r) begin best_r <= rs; bestz_r <= znum; end
              if (znum == zone_r[slot_r]) begin curr_r <= rs; curf_r <= 1'b1; end
            end
          end
          if (!rdv_r && sc_r == (CW+1)'(SCANNERS)) state_r <= S_DONE;
          if (!rdv_r && sc_r == (CW+1)'(SCANNERS)) begin
            if (bestz_r != 4'd0 && zone_r[slot_r] != 4'd0 && curf_r &&
                bestz_r != zone_r[slot_r] && diff < $signed({2'b00, hyst_db}))
              bestz_r <= zone_r[slot_r];
          end
        end
        S_DONE: begin
          // Hand the result to the output register once it is free
          if (!ov_r || res_take) begin
            ov_r       <= 1'b1;
            res_st_r   <= st_r;
            res_slot_r <= oz_r;
            res_zone_r <= bestz_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/tzt_ram.sv @@
// ----------------------------------------------------------------------------
// tzt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tzt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule

@@ design/tag_zone_tracker_core.sv @@
// ----------------------------------------------------------------------------
// tag_zone_tracker_core
// Tag table with strongest-scanner zone selection and hysteresis.
// Each transaction walks all slots serially; evaluate then also reads the
// stored sample of every scanner from the sample memory.
// Throughput: one transaction at a time in the back part; two may queue.
// Reset: synchronous, active low; the table state is cleared in reset and in the clear state after it.
// ----------------------------------------------------------------------------
module tag_zone_tracker_core import tzt_pkg::*; #(
  parameter int TAG_SLOTS = TagSlotsDef,
  parameter int SCANNERS  = ScannersDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_tag_key,
  input  logic [7:0]  in_tag_kind,
  input  logic [3:0]  in_scanner_num,
  input  logic signed [7:0] in_signal_dbm,
  input  logic [31:0] in_now_ms,
  input  logic [3:0]  in_zone_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [3:0]  out_chosen_zone,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] window_r;
  logic [7:0]  hyst_r;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WindowRst;
      hyst_r   <= HystRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW: window_r <= cfg_data;
        CFG_HYST:   hyst_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  cmd_item_t in_item, q_data;
  logic q_empty, q_pop, res_valid;
  assign in_item = '{command: in_command, tag_key: in_tag_key, tag_kind: in_tag_kind,
                     scanner_num: in_scanner_num, signal_dbm: in_signal_dbm,
                     now_ms: in_now_ms, zone_value: in_zone_value};

  tzt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(in_push && !in_full), .wr_data(in_item),
    .full(in_full), .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  tzt_engine #(.TAG_SLOTS(TAG_SLOTS), .SCANNERS(SCANNERS)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .window_ms(window_r), .hyst_db(hyst_r), .res_valid(res_valid),
    .res_status(out_status), .res_slot(out_slot), .res_zone(out_chosen_zone),
    .res_take(out_pop && res_valid)
  );

  assign out_empty = !res_valid;

endmodule
